// ===== design/utfchk_pkg.sv =====
// ----------------------------------------------------------------------------
// utfchk_pkg
// Shared types and constants of the UTF-8 text field checker.
// ----------------------------------------------------------------------------
`default_nettype none

package utfchk_pkg;

  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_CONTROL  = 2'd1;
  localparam logic [1:0] VERDICT_BAD_UTF8 = 2'd2;
  localparam logic [1:0] VERDICT_TOO_LONG = 2'd3;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_DEL   = 8'h7F;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [20:0] CP_MIN2      = 21'h000080;
  localparam logic [20:0] CP_MIN3      = 21'h000800;
  localparam logic [20:0] CP_MIN4      = 21'h010000;
  localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  localparam logic [15:0] MAX_CHARS_RST = 16'd64;

  typedef struct packed {
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [20:0] code_point;
  } utf_state_t;

endpackage

`default_nettype wire

// ===== design/utfchk_decode.sv =====
// ----------------------------------------------------------------------------
// utfchk_decode
// Strict UTF-8 decode step for one non-whitespace byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utfchk_decode
  import utfchk_pkg::*;
(
  input  wire logic [7:0] byte_i,
  input  wire utf_state_t st_i,
  input  wire logic       invalid_i,
  output utf_state_t      st_o,
  output logic            invalid_o,
  output logic            inc_o
);

  logic [20:0] cp_shift;
  logic [1:0]  left_dec;
  logic        bad_cp;

  assign cp_shift = {st_i.code_point[14:0], byte_i[5:0]};
  assign left_dec = st_i.cont_left - 2'd1;
  assign bad_cp   = (st_i.seq_len == SEQ_LEN2 && cp_shift < CP_MIN2) ||
                    (st_i.seq_len == SEQ_LEN3 && cp_shift < CP_MIN3) ||
                    (st_i.seq_len == SEQ_LEN4 && cp_shift < CP_MIN4) ||
                    (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI) ||
                    (cp_shift > CP_MAX);

  always_comb begin
    st_o      = st_i;
    invalid_o = invalid_i;
    inc_o     = 1'b0;
    if (!invalid_i) begin
      if (st_i.cont_left != 2'd0) begin
        if (byte_i[7:6] != 2'b10) begin
          invalid_o    = 1'b1;
          st_o.cont_left = 2'd0;
        end else begin
          st_o.code_point = cp_shift;
          st_o.cont_left  = left_dec;
          if (left_dec == 2'd0) begin
            invalid_o = bad_cp;
            inc_o     = !bad_cp;
          end
        end
      end else if (byte_i[7] == 1'b0) begin
        inc_o = 1'b1;
      end else if (byte_i[7:5] == 3'b110) begin
        st_o.seq_len    = SEQ_LEN2;
        st_o.cont_left  = 2'd1;
        st_o.code_point = {16'd0, byte_i[4:0]};
      end else if (byte_i[7:4] == 4'b1110) begin
        st_o.seq_len    = SEQ_LEN3;
        st_o.cont_left  = 2'd2;
        st_o.code_point = {17'd0, byte_i[3:0]};
      end else if (byte_i[7:3] == 5'b11110) begin
        st_o.seq_len    = SEQ_LEN4;
        st_o.cont_left  = 2'd3;
        st_o.code_point = {18'd0, byte_i[2:0]};
      end else begin
        invalid_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/utf8_text_field_checker_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_text_field_checker_unit
// Trims a byte-wise text field, checks it for control characters and strict
// UTF-8, counts characters and gives one verdict on the last byte.
// ----------------------------------------------------------------------------
//  channel  ports                                          role
//  in       in_valid/in_ready, in_byte_value,              one byte per word
//           in_byte_present, in_is_last
//  out      out_valid/out_ready, out_verdict,              one word per field
//           out_char_count
//  cfg      cfg_valid/cfg_ready, cfg_max_chars             max_chars write
//
//  One byte per clock sustained while no last byte waits on a stalled result;
//  a word is held in the input register, then the field state updates, and on
//  a last byte the result register and out_valid update in the same cycle.
//  A stalled result only blocks a following last byte; other bytes go on.
//  Reset is synchronous; max_chars returns to 64. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_field_checker_unit
  import utfchk_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_byte_present,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_verdict,
  output logic [15:0]      out_char_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_max_chars
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [15:0] max_chars_r;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_present_r;
  logic       in_last_r;
  logic       adv;

  logic                  started_r, started_nxt;
  logic [COUNT_BITS-1:0] pend_r, pend_nxt;
  logic                  pend_ctrl_r, pend_ctrl_nxt;
  utf_state_t            utf_r, utf_nxt, utf_dec;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  ctrl_seen_r, ctrl_seen_nxt;
  logic                  inv_r, inv_nxt, inv_dec;
  logic                  inc_dec;

  logic                  out_vld_r;
  logic [1:0]            verdict_r, verdict_nxt;
  logic [15:0]           ccount_r, ccount_nxt;

  logic                  is_space, is_ctrl, take_text, add_pend;
  logic [COUNT_BITS+1:0] sum;
  logic [COUNT_BITS-1:0] count_sat;
  logic [CMP_W-1:0]      count_ext;

  assign cfg_ready = 1'b1;

  assign adv      = in_vld_r && (!in_last_r || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  assign is_space = (in_byte_r == CHR_SPACE) || (in_byte_r == CHR_TAB) ||
                    (in_byte_r == CHR_CR) || (in_byte_r == CHR_LF);
  assign is_ctrl  = (in_byte_r < CHR_SPACE) || (in_byte_r == CHR_DEL);
  assign take_text = in_present_r && !is_space;
  assign add_pend  = take_text && !inv_r && (pend_r != '0);

  utfchk_decode u_decode (
    .byte_i    (in_byte_r),
    .st_i      (utf_r),
    .invalid_i (inv_r),
    .st_o      (utf_dec),
    .invalid_o (inv_dec),
    .inc_o     (inc_dec)
  );

  assign sum = {2'b00, count_r} + (add_pend ? {2'b00, pend_r} : '0) +
               {{(COUNT_BITS+1){1'b0}}, take_text & inc_dec};
  assign count_sat = (sum[COUNT_BITS+1:COUNT_BITS] != 2'b00) ? CNT_MAX
                                                             : sum[COUNT_BITS-1:0];
  assign count_ext = CMP_W'(count_sat);

  always_comb begin
    started_nxt   = started_r;
    pend_nxt      = pend_r;
    pend_ctrl_nxt = pend_ctrl_r;
    utf_nxt       = utf_r;
    count_nxt     = count_sat;
    ctrl_seen_nxt = ctrl_seen_r;
    inv_nxt       = inv_r;
    if (in_present_r) begin
      if (is_space) begin
        if (started_r) begin
          if (utf_r.cont_left != 2'd0 && !inv_r) begin
            inv_nxt           = 1'b1;
            utf_nxt.cont_left = 2'd0;
          end
          pend_nxt = (pend_r == CNT_MAX) ? pend_r : pend_r + 1'b1;
          if (in_byte_r != CHR_SPACE) begin
            pend_ctrl_nxt = 1'b1;
          end
        end
      end else begin
        started_nxt   = 1'b1;
        pend_nxt      = '0;
        pend_ctrl_nxt = 1'b0;
        if ((pend_r != '0 && pend_ctrl_r) || is_ctrl) begin
          ctrl_seen_nxt = 1'b1;
        end
        utf_nxt = utf_dec;
        inv_nxt = inv_dec;
      end
    end
    if (in_last_r && utf_nxt.cont_left != 2'd0) begin
      inv_nxt = 1'b1;
    end

    ccount_nxt = (count_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : count_ext[15:0];
    if (ctrl_seen_nxt) begin
      verdict_nxt = VERDICT_CONTROL;
      ccount_nxt  = 16'd0;
    end else if (inv_nxt) begin
      verdict_nxt = VERDICT_BAD_UTF8;
      ccount_nxt  = 16'd0;
    end else if (count_ext > CMP_W'(max_chars_r)) begin
      verdict_nxt = VERDICT_TOO_LONG;
    end else begin
      verdict_nxt = VERDICT_OK;
    end

    if (in_last_r) begin
      started_nxt   = 1'b0;
      pend_nxt      = '0;
      pend_ctrl_nxt = 1'b0;
      utf_nxt       = '0;
      count_nxt     = '0;
      ctrl_seen_nxt = 1'b0;
      inv_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= MAX_CHARS_RST;
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      started_r   <= 1'b0;
      pend_r      <= '0;
      pend_ctrl_r <= 1'b0;
      utf_r       <= '0;
      count_r     <= '0;
      ctrl_seen_r <= 1'b0;
      inv_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_chars_r <= cfg_max_chars;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        started_r   <= started_nxt;
        pend_r      <= pend_nxt;
        pend_ctrl_r <= pend_ctrl_nxt;
        utf_r       <= utf_nxt;
        count_r     <= count_nxt;
        ctrl_seen_r <= ctrl_seen_nxt;
        inv_r       <= inv_nxt;
      end
      if (adv && in_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r    <= in_byte_value;
      in_present_r <= in_byte_present;
      in_last_r    <= in_is_last;
    end
    if (adv && in_last_r) begin
      verdict_r <= verdict_nxt;
      ccount_r  <= ccount_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_verdict    = verdict_r;
  assign out_char_count = ccount_r;

endmodule

`default_nettype wire

// ===== design/utfchk_checker.sv =====
// ----------------------------------------------------------------------------
// utfchk_checker
// Port-level checks of the UTF-8 text field checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utfchk_checker
  import utfchk_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_verdict,
  input wire logic [15:0] out_char_count,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
                                $stable(out_char_count))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_CONTROL || out_verdict == VERDICT_BAD_UTF8)
      |-> out_char_count == 16'd0)
    else $error("rejected field reports a count");

  a_long_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_TOO_LONG |-> out_char_count != 16'd0)
    else $error("too long with zero count");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind utf8_text_field_checker_unit utfchk_checker u_utfchk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_verdict    (out_verdict),
  .out_char_count (out_char_count),
  .cfg_ready      (cfg_ready)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 text field checker. Fields are fed one
// byte per word with random gaps on both channels. A scoreboard tracks trim,
// pending whitespace, control and UTF-8 state on every accepted word and
// checks each verdict word. The max_chars limit is changed between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utfchk_pkg::*;

  localparam int PHASE_WORDS   = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 3000;

  typedef struct {
    logic [1:0]  verdict;
    logic [15:0] count;
  } field_result_t;

  typedef enum int {
    K_ASCII, K_WS, K_CTRL, K_MULTI, K_OVERLONG, K_SURR, K_ABOVE, K_STRAY, K_TRUNC, K_SPACE
  } char_kind_e;

  class field_verdict_board;
    logic [15:0]   max_chars;
    bit            started, pend_ctrl, ctrl_seen, bad_seen;
    logic [15:0]   pend_ws, chars;
    logic [1:0]    cont_left;
    logic [2:0]    seq_len;
    logic [20:0]   cp;
    field_result_t expected_verdicts[$];
    int            mismatches, results_seen;
    int            tally[4];

    function new();
      max_chars = MAX_CHARS_RST;
      mismatches = 0;
      results_seen = 0;
      foreach (tally[i]) tally[i] = 0;
      clear_field();
    endfunction

    function void clear_field();
      started = 0;
      pend_ws = '0;
      pend_ctrl = 0;
      cont_left = '0;
      seq_len = '0;
      cp = '0;
      chars = '0;
      ctrl_seen = 0;
      bad_seen = 0;
    endfunction

    function logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function void note_byte(logic [7:0] b_val, bit present, bit last);
      field_result_t r;
      if (present) begin
        if (b_val == CHR_SPACE || b_val == CHR_TAB || b_val == CHR_CR || b_val == CHR_LF) begin
          if (started) begin
            if (cont_left != 0 && !bad_seen) begin
              bad_seen = 1;
              cont_left = '0;
            end
            pend_ws = sat_add(pend_ws, 16'd1);
            if (b_val != CHR_SPACE) pend_ctrl = 1;
          end
        end else begin
          started = 1;
          if (pend_ws != 0) begin
            if (!bad_seen) chars = sat_add(chars, pend_ws);
            if (pend_ctrl) ctrl_seen = 1;
            pend_ws = '0;
            pend_ctrl = 0;
          end
          if (b_val < CHR_SPACE || b_val == CHR_DEL) ctrl_seen = 1;
          if (!bad_seen) begin
            if (cont_left != 0) begin
              if (b_val[7:6] != 2'b10) begin
                bad_seen = 1;
                cont_left = '0;
              end else begin
                cp = {cp[14:0], b_val[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                  if ((seq_len == SEQ_LEN2 && cp < CP_MIN2) ||
                      (seq_len == SEQ_LEN3 && cp < CP_MIN3) ||
                      (seq_len == SEQ_LEN4 && cp < CP_MIN4) ||
                      (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp > CP_MAX)
                    bad_seen = 1;
                  else
                    chars = sat_add(chars, 16'd1);
                end
              end
            end else if (!b_val[7]) begin
              chars = sat_add(chars, 16'd1);
            end else if (b_val[7:5] == 3'b110) begin
              seq_len = SEQ_LEN2;
              cont_left = 2'd1;
              cp = {16'd0, b_val[4:0]};
            end else if (b_val[7:4] == 4'b1110) begin
              seq_len = SEQ_LEN3;
              cont_left = 2'd2;
              cp = {17'd0, b_val[3:0]};
            end else if (b_val[7:3] == 5'b11110) begin
              seq_len = SEQ_LEN4;
              cont_left = 2'd3;
              cp = {18'd0, b_val[2:0]};
            end else begin
              bad_seen = 1;
            end
          end
        end
      end
      if (last) begin
        if (cont_left != 0) bad_seen = 1;
        r.count = chars;
        if (ctrl_seen) begin
          r.verdict = VERDICT_CONTROL;
          r.count = '0;
        end else if (bad_seen) begin
          r.verdict = VERDICT_BAD_UTF8;
          r.count = '0;
        end else if (chars > max_chars) begin
          r.verdict = VERDICT_TOO_LONG;
        end else begin
          r.verdict = VERDICT_OK;
        end
        expected_verdicts.insert(expected_verdicts.size(), r);
        clear_field();
      end
    endfunction

    function void check_result(logic [1:0] verdict, logic [15:0] count);
      field_result_t want;
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected verdict word %0d: verdict %0d count %0d",
                   results_seen, verdict, count);
      end else begin
        want = expected_verdicts.pop_front();
        tally[want.verdict]++;
        if (want.verdict !== verdict || want.count !== count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: field %0d expected verdict %0d count %0d, got %0d count %0d",
                     results_seen, want.verdict, want.count, verdict, count);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_value;
  logic        in_byte_present;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_verdict;
  logic [15:0] out_char_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_chars;

  field_verdict_board board;
  logic [7:0]         field_text[$];
  logic [9:0]         directed_words[$];
  bit                 steady;
  bit                 hold_request;
  int                 words_sent;
  int                 cfg_writes;
  int                 stall_cycles;

  utf8_text_field_checker_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_value   (in_byte_value),
    .in_byte_present (in_byte_present),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_verdict     (out_verdict),
    .out_char_count  (out_char_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_chars   (cfg_max_chars)
  );

  always #5 clk = ~clk;

  function automatic void append_byte(logic [7:0] b);
    field_text.insert(field_text.size(), b);
  endfunction

  function automatic logic [20:0] valid_code(int n);
    logic [20:0] c;
    case (n)
      2: c = 21'($urandom_range(21'h80, 21'h7FF));
      3: begin
        c = 21'($urandom_range(21'h800, 21'hFFFF));
        if (c >= CP_SURR_LO && c <= CP_SURR_HI) c = c - 21'h800;
      end
      default: c = 21'($urandom_range(21'h10000, 21'h10FFFF));
    endcase
    return c;
  endfunction

  function automatic void push_code(logic [20:0] c, int n);
    case (n)
      2: append_byte({3'b110, c[10:6]});
      3: append_byte({4'b1110, c[15:12]});
      default: append_byte({5'b11110, c[20:18]});
    endcase
    for (int i = n - 2; i >= 0; i--) append_byte({2'b10, c[6*i +: 6]});
  endfunction

  function automatic void add_char(char_kind_e kind);
    int n;
    int r;
    n = $urandom_range(2, 4);
    case (kind)
      K_ASCII: append_byte(8'($urandom_range(8'h21, 8'h7E)));
      K_WS: begin
        r = $urandom_range(0, 3);
        append_byte(r == 0 ? CHR_SPACE : r == 1 ? CHR_TAB : r == 2 ? CHR_CR : CHR_LF);
      end
      K_CTRL: begin
        r = $urandom_range(0, 32);
        append_byte(r == 32 ? CHR_DEL : 8'(r));
      end
      K_MULTI: push_code(valid_code(n), n);
      K_OVERLONG: begin
        case (n)
          2: push_code(21'($urandom_range(0, 21'h7F)), n);
          3: push_code(21'($urandom_range(0, 21'h7FF)), n);
          default: push_code(21'($urandom_range(0, 21'hFFFF)), n);
        endcase
      end
      K_SURR: push_code(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
      K_ABOVE: push_code(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      K_STRAY: append_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                : 8'($urandom_range(8'hF8, 8'hFF)));
      K_TRUNC: begin
        push_code(valid_code(n), n);
        repeat ($urandom_range(1, n - 1)) void'(field_text.pop_back());
      end
      default: append_byte(CHR_SPACE);
    endcase
  endfunction

  function automatic void make_field();
    int  n_chars;
    int  r;
    bit  clean;
    field_text.delete();
    clean = $urandom_range(0, 3) != 0;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 12);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) add_char(K_WS);
    repeat (n_chars) begin
      if (clean) begin
        r = $urandom_range(0, 9);
        add_char(r < 5 ? K_ASCII : r < 8 ? K_MULTI : K_SPACE);
      end else begin
        add_char(char_kind_e'($urandom_range(0, K_SPACE)));
      end
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) add_char(K_WS);
  endfunction

  task automatic send_word(input logic [7:0] v, input bit present, input bit last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_byte_value = v;
    in_byte_present = present;
    in_is_last = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_byte(v, present, last);
    if (present || last) words_sent++;
    @(negedge clk);
  endtask

  task automatic send_field(input bit marker_end);
    int n;
    n = field_text.size();
    for (int i = 0; i < n; i++) begin
      if (!steady && $urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(field_text[i], 1'b1, !marker_end && i == n - 1);
    end
    if (marker_end || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic run_phase(input bit with_hold);
    int start;
    start = words_sent;
    hold_request = with_hold;
    while (words_sent - start < PHASE_WORDS) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      make_field();
      send_field($urandom_range(0, 7) == 0);
    end
    steady = 1'b0;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (board.expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_max_chars(input logic [15:0] value);
    drain_results();
    cfg_max_chars = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.max_chars = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 15);
      end
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_verdict, out_char_count);
      @(negedge clk);
    end
  end

  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_value = '0;
    in_byte_present = 1'b0;
    in_is_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_max_chars = '0;
    steady = 1'b0;
    hold_request = 1'b0;
    words_sent = 0;
    cfg_writes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // {present, last, byte}
    directed_words = '{
      {2'b01, 8'hFF},
      {2'b10, CHR_SPACE}, {2'b10, 8'h41}, {2'b00, 8'h00}, {2'b11, CHR_TAB},
      {2'b10, 8'h61}, {2'b10, CHR_TAB}, {2'b11, 8'h62},
      {2'b10, 8'hFF}, {2'b11, 8'h01},
      {2'b10, 8'hC3}, {2'b11, 8'hA9},
      {2'b10, 8'hED}, {2'b10, 8'hA0}, {2'b11, 8'h80},
      {2'b10, 8'hE2}, {2'b10, CHR_SPACE}, {2'b11, 8'h82},
      {2'b10, 8'hF0}, {2'b11, 8'h9F},
      {2'b10, CHR_DEL}, {2'b01, 8'h00},
      {2'b11, 8'h00},
      {2'b10, 8'hC1}, {2'b11, 8'hBF}
    };
    foreach (directed_words[i])
      send_word(directed_words[i][7:0], directed_words[i][9], directed_words[i][8]);

    run_phase(1'b1);
    write_max_chars(16'd0);
    run_phase(1'b0);

    write_max_chars(16'hFFFF);
    run_phase(1'b0);

    write_max_chars(16'd1);
    run_phase(1'b0);
    write_max_chars(16'($urandom_range(2, 40)));
    run_phase(1'b0);
    write_max_chars(16'd12);
    run_phase(1'b0);

    drain_results();
    $display("Sent %0d words over %0d max_chars settings; %0d verdict words checked",
             words_sent, cfg_writes + 1, board.results_seen);
    $display("Verdicts: %0d ok, %0d control, %0d bad UTF-8, %0d too long; %0d mismatches",
             board.tally[VERDICT_OK], board.tally[VERDICT_CONTROL],
             board.tally[VERDICT_BAD_UTF8], board.tally[VERDICT_TOO_LONG], board.mismatches);
    if (board.mismatches == 0 && board.expected_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/utfchk_pkg.sv
design/utfchk_decode.sv
design/utf8_text_field_checker_unit.sv
design/utfchk_checker.sv
tb/sv/tb.sv
